>>> src/ps2_scancode_to_ascii_macros.svh
// Assertion macros for the scan code decoder.
`ifndef PS2_SCANCODE_TO_ASCII_MACROS_SVH
`define PS2_SCANCODE_TO_ASCII_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define PS2KBD_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PS2KBD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/ps2kbd_pkg.sv
package ps2kbd_pkg;

   localparam logic [7:0] PREFIX_RELEASE = 8'hF0;
   localparam logic [7:0] MARK_NULL      = 8'h80;
   localparam logic [7:0] MARK_SHIFT     = 8'h81;
   localparam logic [7:0] MARK_CTRL      = 8'h82;
   localparam logic [7:0] NO_ENTRY       = 8'h00;

   typedef struct packed {
      logic       is_shift;
      logic       is_ctrl;
      logic       has_char;
      logic [6:0] char_code;
   } lookup_type;

   function automatic logic [7:0] plain_entry(input logic [6:0] code);
      logic [7:0] e;
      unique case (code)
         7'h0D: e = 8'h09;
         7'h0E: e = 8'h60;
         7'h12: e = MARK_SHIFT;
         7'h14: e = MARK_CTRL;
         7'h15: e = 8'h71;
         7'h16: e = 8'h31;
         7'h1A: e = 8'h7A;
         7'h1B: e = 8'h73;
         7'h1C: e = 8'h61;
         7'h1D: e = 8'h77;
         7'h1E: e = 8'h32;
         7'h21: e = 8'h63;
         7'h22: e = 8'h78;
         7'h23: e = 8'h64;
         7'h24: e = 8'h65;
         7'h25: e = 8'h34;
         7'h26: e = 8'h33;
         7'h29: e = 8'h20;
         7'h2A: e = 8'h76;
         7'h2B: e = 8'h66;
         7'h2C: e = 8'h74;
         7'h2D: e = 8'h72;
         7'h2E: e = 8'h35;
         7'h31: e = 8'h6E;
         7'h32: e = 8'h62;
         7'h33: e = 8'h68;
         7'h34: e = 8'h67;
         7'h35: e = 8'h79;
         7'h36: e = 8'h36;
         7'h3A: e = 8'h6D;
         7'h3B: e = 8'h6A;
         7'h3C: e = 8'h75;
         7'h3D: e = 8'h37;
         7'h3E: e = 8'h38;
         7'h41: e = 8'h2C;
         7'h42: e = 8'h6B;
         7'h43: e = 8'h69;
         7'h44: e = 8'h6F;
         7'h45: e = 8'h30;
         7'h46: e = 8'h39;
         7'h49: e = 8'h2E;
         7'h4A: e = 8'h2F;
         7'h4B: e = 8'h6C;
         7'h4C: e = 8'h3B;
         7'h4D: e = 8'h70;
         7'h4E: e = 8'h2D;
         7'h52: e = 8'h27;
         7'h54: e = 8'h5B;
         7'h55: e = 8'h3D;
         7'h59: e = MARK_SHIFT;
         7'h5A: e = 8'h0A;
         7'h5B: e = 8'h5D;
         7'h5D: e = 8'h5C;
         7'h66: e = 8'h08;
         7'h75: e = 8'h1B;
         default: e = NO_ENTRY;
      endcase
      return e;
   endfunction

   function automatic logic [7:0] shift_entry(input logic [6:0] code);
      logic [7:0] e;
      unique case (code)
         7'h0D: e = 8'h09;
         7'h0E: e = 8'h7E;
         7'h12: e = MARK_SHIFT;
         7'h14: e = MARK_CTRL;
         7'h15: e = 8'h51;
         7'h16: e = 8'h21;
         7'h1A: e = 8'h5A;
         7'h1B: e = 8'h53;
         7'h1C: e = 8'h41;
         7'h1D: e = 8'h57;
         7'h1E: e = 8'h40;
         7'h21: e = 8'h43;
         7'h22: e = 8'h58;
         7'h23: e = 8'h44;
         7'h24: e = 8'h45;
         7'h25: e = 8'h24;
         7'h26: e = 8'h23;
         7'h29: e = 8'h20;
         7'h2A: e = 8'h56;
         7'h2B: e = 8'h46;
         7'h2C: e = 8'h54;
         7'h2D: e = 8'h52;
         7'h2E: e = 8'h25;
         7'h31: e = 8'h4E;
         7'h32: e = 8'h42;
         7'h33: e = 8'h48;
         7'h34: e = 8'h47;
         7'h35: e = 8'h59;
         7'h36: e = 8'h5E;
         7'h3A: e = 8'h4D;
         7'h3B: e = 8'h4A;
         7'h3C: e = 8'h55;
         7'h3D: e = 8'h26;
         7'h3E: e = 8'h2A;
         7'h41: e = 8'h3C;
         7'h42: e = 8'h4B;
         7'h43: e = 8'h49;
         7'h44: e = 8'h4F;
         7'h45: e = 8'h29;
         7'h46: e = 8'h28;
         7'h49: e = 8'h3E;
         7'h4A: e = 8'h3F;
         7'h4B: e = 8'h4C;
         7'h4C: e = 8'h3A;
         7'h4D: e = 8'h50;
         7'h4E: e = 8'h5F;
         7'h52: e = 8'h22;
         7'h54: e = 8'h7B;
         7'h55: e = 8'h2B;
         7'h59: e = MARK_SHIFT;
         7'h5A: e = 8'h0A;
         7'h5B: e = 8'h7D;
         7'h5D: e = 8'h7C;
         7'h66: e = 8'h08;
         7'h75: e = 8'h1B;
         default: e = NO_ENTRY;
      endcase
      return e;
   endfunction

   function automatic logic [7:0] ctrl_entry(input logic [6:0] code);
      logic [7:0] e;
      unique case (code)
         7'h0D: e = 8'h09;
         7'h0E: e = 8'h7E;
         7'h12: e = MARK_SHIFT;
         7'h14: e = MARK_CTRL;
         7'h15: e = 8'h11;
         7'h16: e = 8'h21;
         7'h1A: e = 8'h1A;
         7'h1B: e = 8'h13;
         7'h1C: e = 8'h01;
         7'h1D: e = 8'h17;
         7'h1E: e = 8'h40;
         7'h21: e = 8'h03;
         7'h22: e = 8'h18;
         7'h23: e = 8'h04;
         7'h24: e = 8'h05;
         7'h25: e = 8'h24;
         7'h26: e = 8'h23;
         7'h29: e = MARK_NULL;
         7'h2A: e = 8'h16;
         7'h2B: e = 8'h06;
         7'h2C: e = 8'h14;
         7'h2D: e = 8'h12;
         7'h2E: e = 8'h25;
         7'h31: e = 8'h0E;
         7'h32: e = 8'h02;
         7'h33: e = 8'h08;
         7'h34: e = 8'h07;
         7'h35: e = 8'h19;
         7'h36: e = 8'h1F;
         7'h3A: e = 8'h0D;
         7'h3B: e = 8'h0A;
         7'h3C: e = 8'h15;
         7'h3D: e = 8'h26;
         7'h3E: e = 8'h2A;
         7'h41: e = 8'h3C;
         7'h42: e = 8'h0B;
         7'h43: e = 8'h09;
         7'h44: e = 8'h0F;
         7'h45: e = 8'h29;
         7'h46: e = 8'h28;
         7'h49: e = 8'h3E;
         7'h4A: e = 8'h3F;
         7'h4B: e = 8'h0C;
         7'h4C: e = 8'h3A;
         7'h4D: e = 8'h10;
         7'h4E: e = 8'h5F;
         7'h52: e = 8'h22;
         7'h54: e = 8'h1B;
         7'h55: e = 8'h2B;
         7'h59: e = MARK_SHIFT;
         7'h5A: e = 8'h0A;
         7'h5B: e = 8'h1D;
         7'h5D: e = 8'h1C;
         7'h66: e = 8'h08;
         7'h75: e = 8'h1B;
         default: e = NO_ENTRY;
      endcase
      return e;
   endfunction

endpackage

>>> src/ps2kbd_lookup.sv
module ps2kbd_lookup (
   input  logic [6:0]             code,
   input  logic                   shift_held,
   input  logic                   ctrl_held,
   output ps2kbd_pkg::lookup_type info
);

   logic [7:0] entry;

   always_comb begin
      priority if (ctrl_held) begin
         entry = ps2kbd_pkg::ctrl_entry(code);
      end else if (shift_held) begin
         entry = ps2kbd_pkg::shift_entry(code);
      end else begin
         entry = ps2kbd_pkg::plain_entry(code);
      end
   end

   always_comb begin
      info.is_shift  = (entry == ps2kbd_pkg::MARK_SHIFT);
      info.is_ctrl   = (entry == ps2kbd_pkg::MARK_CTRL);
      // null marker has low bits zero, so it yields character 0
      info.has_char  = (entry != ps2kbd_pkg::NO_ENTRY) && !info.is_shift && !info.is_ctrl;
      info.char_code = entry[6:0];
   end

endmodule

>>> src/ps2_scancode_to_ascii.sv
// Channel   Ports                                   Moves
// req       req_valid, req_ready, req_scan_byte     one scan code byte per request
// rsp       rsp_valid, rsp_ready, rsp_char_code     zero or one character per request
//
// One request accepted per cycle while the skid is empty; rsp_char_code is registered.
// Table lookup and flag update sit between the request port and the result register.
// A skid register holds one result while rsp stalls; req_ready drops only while it is full.
// Synchronous reset clears the release, shift and ctrl flags and both valid bits.
module ps2_scancode_to_ascii (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_scan_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [6:0] rsp_char_code
);

`include "ps2_scancode_to_ascii_macros.svh"

   logic release_pending_ff, release_pending_in;
   logic shift_held_ff, shift_held_in;
   logic ctrl_held_ff, ctrl_held_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [6:0] rsp_char_ff, rsp_char_in;
   logic skid_valid_ff, skid_valid_in;
   logic [6:0] skid_char_ff, skid_char_in;

   ps2kbd_pkg::lookup_type info;
   logic accept, is_prefix, press, mapped, has_result, out_take;

   ps2kbd_lookup u_lookup (
      .code       (req_scan_byte[6:0]),
      .shift_held (shift_held_ff),
      .ctrl_held  (ctrl_held_ff),
      .info       (info)
   );

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign out_take  = rsp_valid_ff && rsp_ready;

   assign is_prefix  = !release_pending_ff && (req_scan_byte == ps2kbd_pkg::PREFIX_RELEASE);
   assign press      = !release_pending_ff;
   assign mapped     = !req_scan_byte[7];
   assign has_result = accept && mapped && press && info.has_char;

   always_comb begin
      release_pending_in = release_pending_ff;
      shift_held_in      = shift_held_ff;
      ctrl_held_in       = ctrl_held_ff;
      if (accept) begin
         release_pending_in = is_prefix;
         if (mapped && info.is_ctrl) begin
            ctrl_held_in = press;
         end
         if (mapped && info.is_shift) begin
            shift_held_in = press;
         end
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !out_take;
      rsp_char_in   = rsp_char_ff;
      skid_valid_in = skid_valid_ff;
      skid_char_in  = skid_char_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            rsp_valid_in  = 1'b1;
            rsp_char_in   = skid_char_ff;
            skid_valid_in = 1'b0;
         end
      end else if (has_result) begin
         if (!rsp_valid_ff || out_take) begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = info.char_code;
         end else begin
            skid_valid_in = 1'b1;
            skid_char_in  = info.char_code;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         release_pending_ff <= 1'b0;
         shift_held_ff      <= 1'b0;
         ctrl_held_ff       <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         skid_valid_ff      <= 1'b0;
      end else begin
         release_pending_ff <= release_pending_in;
         shift_held_ff      <= shift_held_in;
         ctrl_held_ff       <= ctrl_held_in;
         rsp_valid_ff       <= rsp_valid_in;
         skid_valid_ff      <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_char_ff  <= rsp_char_in;
      skid_char_ff <= skid_char_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;

   `PS2KBD_ASSERT_IMPL(a_skid_behind_out, skid_valid_ff, rsp_valid_ff,
                       "skid full with empty output")
   `PS2KBD_ASSERT_NEXT(a_prefix_sets_pending, accept && is_prefix, release_pending_ff,
                       "release prefix not recorded")
   `PS2KBD_ASSERT_NEXT(a_ctrl_release_clears,
                       accept && release_pending_ff && mapped && info.is_ctrl,
                       !ctrl_held_ff, "ctrl release ignored")

endmodule
